// ----- hdl/hsbs_pkg.sv -----
`default_nettype none
package hsbs_pkg;
	localparam int MaxBytes = 1048576;
	localparam int MinPeriod = 4;
	localparam int MaxPeriod = 16;
	localparam int Lanes = MaxPeriod - MinPeriod + 1;
	localparam int CntW = 21;
	localparam int MatchW = 19;
	localparam int PhaseW = 4;
	localparam int PerW = 5;
	localparam logic [7:0] NopByte = 8'h90;
	localparam logic [47:0] BigRegion = 48'h100000;

	localparam logic [1:0] RegNopEnable = 2'd0;
	localparam logic [1:0] RegMinRepeat = 2'd1;
	localparam logic [1:0] RegMinDensity = 2'd2;
	localparam logic [1:0] RegRunThresh = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last;
		logic [47:0] region_size;
	} in_req_t;

	typedef struct packed {
		logic nop_found;
		logic [20:0] nop_count;
		logic [20:0] longest_run;
		logic spray_detected;
		logic [6:0] risk_score;
		logic likely_exploit;
		logic sequence_found;
		logic [4:0] sequence_period;
		logic [18:0] sequence_matches;
	} out_req_t;

	typedef struct packed {
		logic nop_enable;
		logic [20:0] min_repeat_count;
		logic [6:0] min_density_pct;
		logic [20:0] run_threshold;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic scan;      // take the input byte into the counters and lanes
		logic latch_end; // capture region size and start the judge
		logic div_step;  // one restoring division step
		logic finish;    // build the result and clear region state
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

// ----- hdl/hsbs_ctrl.sv -----
`default_nettype none
module hsbs_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_last,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire hsbs_pkg::sts_t sts,
	output hsbs_pkg::cmd_t cmd
);
	import hsbs_pkg::*;

	typedef enum logic [2:0] {
		ST_SCAN = 3'b001,
		ST_DIV = 3'b010,
		ST_OUT = 3'b100
	} state_t;

	state_t state_q;
	logic acc;

	// One byte per cycle while scanning; after the last it divides, then holds the result.
	assign in_ready = (state_q == ST_SCAN);
	assign acc = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.scan = acc;
		cmd.latch_end = acc && in_last;
		cmd.div_step = (state_q == ST_DIV) && !sts.div_done;
		cmd.finish = (state_q == ST_DIV) && sts.div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
		end else begin
			unique case (state_q)
				ST_SCAN: if (acc && in_last) state_q <= ST_DIV;
				ST_DIV: if (sts.div_done) state_q <= ST_OUT;
				ST_OUT: if (out_ready) state_q <= ST_SCAN;
				default: state_q <= ST_SCAN;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/hsbs_dp.sv -----
`default_nettype none
module hsbs_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire hsbs_pkg::in_req_t in_req,
	input wire hsbs_pkg::cfg_t cfg,
	input wire hsbs_pkg::cmd_t cmd,
	output hsbs_pkg::sts_t sts,
	output hsbs_pkg::out_req_t out_req
);
	import hsbs_pkg::*;

	localparam int QW = 5; // floor(30*cnt/n) <= 30

	logic [7:0] hist_q [MaxPeriod];
	logic [CntW:0] scanned_q;
	logic [CntW:0] nop_q;
	logic [CntW:0] run_q;
	logic [CntW:0] max_q;
	logic [MatchW:0] match_q [Lanes];
	logic [PhaseW-1:0] phase_q [Lanes];
	logic mism_q [Lanes];
	logic big_q;
	logic [2:0] div_cnt_q;
	logic [26:0] rem_q;
	logic [QW-1:0] quo_q;
	logic sled_q, det_q, seq_q;
	logic [PerW-1:0] per_q;
	logic [MatchW:0] seqm_q;
	out_req_t out_q;

	logic take;
	assign take = cmd.scan && (scanned_q < (CntW+1)'(MaxBytes));

	// Next counter values include the byte of this request.
	logic is_nop;
	logic [CntW:0] n_nxt, cnt_nxt, run_nxt, max_nxt;
	assign is_nop = (in_req.data_byte == NopByte);
	assign n_nxt = take ? scanned_q + 1'b1 : scanned_q;
	assign cnt_nxt = (take && is_nop) ? nop_q + 1'b1 : nop_q;
	assign run_nxt = take ? (is_nop ? run_q + 1'b1 : '0) : run_q;
	assign max_nxt = (run_nxt > max_q) ? run_nxt : max_q;

	logic [MatchW:0] match_nxt [Lanes];
	logic [PhaseW-1:0] phase_nxt [Lanes];
	logic mism_nxt [Lanes];
	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			logic d, m;
			d = (in_req.data_byte != hist_q[MinPeriod + l - 1]);
			m = (phase_q[l] == '0) ? d : (mism_q[l] || d);
			match_nxt[l] = match_q[l];
			phase_nxt[l] = phase_q[l];
			mism_nxt[l] = mism_q[l];
			if (take) begin
				if ({1'b0, phase_q[l]} + 1'b1 >= (PhaseW+1)'(MinPeriod + l)) begin
					if (!m && scanned_q >= (CntW+1)'(MinPeriod + l))
						match_nxt[l] = match_q[l] + 1'b1;
					phase_nxt[l] = '0;
					mism_nxt[l] = 1'b0;
				end else begin
					phase_nxt[l] = phase_q[l] + 1'b1;
					mism_nxt[l] = m;
				end
			end
		end
	end

	// Judge terms from the final counters, all evaluated at the last byte.
	// A lane qualifies when n >= 4p and matches > floor(n/(4p)), that is when matches*4p > n.
	logic sled_c, det_c, seq_c;
	logic [PerW-1:0] per_c;
	logic [MatchW:0] seqm_c;
	logic [28:0] c100, dn;
	always_comb begin
		sled_c = (cnt_nxt > (n_nxt >> 2)) || (max_nxt > {1'b0, cfg.run_threshold});
		c100 = 29'(cnt_nxt) * 29'd100;
		dn = 29'(cfg.min_density_pct) * 29'(n_nxt);
		det_c = cfg.nop_enable && sled_c && (cnt_nxt >= {1'b0, cfg.min_repeat_count})
			&& (c100 >= dn) && (n_nxt != '0);
		seq_c = 1'b0;
		per_c = '0;
		seqm_c = '0;
		for (int l = Lanes - 1; l >= 0; l--) begin
			if (n_nxt >= (CntW+1)'(4 * (MinPeriod + l))
					&& 26'(match_nxt[l]) * 26'(4 * (MinPeriod + l)) > 26'(n_nxt)) begin
				seq_c = 1'b1;
				per_c = PerW'(MinPeriod + l);
				seqm_c = match_nxt[l];
			end
		end
	end

	assign sts.div_done = (div_cnt_q == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanned_q <= '0; nop_q <= '0; run_q <= '0; max_q <= '0;
			div_cnt_q <= '0;
			for (int i = 0; i < MaxPeriod; i++) hist_q[i] <= '0;
			for (int l = 0; l < Lanes; l++) begin
				match_q[l] <= '0; phase_q[l] <= '0; mism_q[l] <= 1'b0;
			end
		end else begin
			if (cmd.scan) begin
				scanned_q <= n_nxt; nop_q <= cnt_nxt; run_q <= run_nxt; max_q <= max_nxt;
				for (int l = 0; l < Lanes; l++) begin
					match_q[l] <= match_nxt[l]; phase_q[l] <= phase_nxt[l];
					mism_q[l] <= mism_nxt[l];
				end
				if (take) begin
					hist_q[0] <= in_req.data_byte;
					for (int i = 1; i < MaxPeriod; i++) hist_q[i] <= hist_q[i-1];
				end
			end
			if (cmd.latch_end) div_cnt_q <= 3'(QW);
			else if (cmd.div_step) div_cnt_q <= div_cnt_q - 1'b1;
			if (cmd.finish) begin
				scanned_q <= '0; nop_q <= '0; run_q <= '0; max_q <= '0;
				for (int i = 0; i < MaxPeriod; i++) hist_q[i] <= '0;
				for (int l = 0; l < Lanes; l++) begin
					match_q[l] <= '0; phase_q[l] <= '0; mism_q[l] <= 1'b0;
				end
			end
		end
	end

	// 30*cnt / n: the quotient is at most 30, so the remainder starts at (30*cnt) >> 5
	// and five steps shift in the low numerator bits, most significant first.
	logic [26:0] num30_c;
	logic [4:0] num_low_q;
	logic [26:0] rem_sh;
	logic [26:0] nn;
	assign num30_c = 27'(cnt_nxt) * 27'd30;
	assign nn = 27'(scanned_q);
	assign rem_sh = {rem_q[25:0], num_low_q[div_cnt_q - 3'd1]};

	always_ff @(posedge clk) begin
		if (cmd.latch_end) begin
			rem_q <= num30_c >> 5;
			num_low_q <= num30_c[4:0];
			quo_q <= '0;
			big_q <= in_req.region_size > BigRegion;
			sled_q <= cfg.nop_enable && sled_c;
			det_q <= det_c;
			seq_q <= seq_c; per_q <= per_c; seqm_q <= seqm_c;
		end else if (cmd.div_step) begin
			if (rem_sh >= nn) begin
				rem_q <= rem_sh - nn;
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			logic [7:0] r;
			r = 8'd50 + 8'(quo_q) + (big_q ? 8'd20 : 8'd0);
			if (r > 8'd100) r = 8'd100;
			out_q.nop_found <= sled_q;
			out_q.nop_count <= CntW'(nop_q);
			out_q.longest_run <= CntW'(max_q);
			out_q.spray_detected <= det_q;
			out_q.risk_score <= det_q ? 7'(r) : 7'd0;
			out_q.likely_exploit <= det_q && ((29'(nop_q) * 29'd10 > 29'(scanned_q) * 29'd9)
				|| r > 8'd70);
			out_q.sequence_found <= seq_q;
			out_q.sequence_period <= per_q;
			out_q.sequence_matches <= MatchW'(seqm_q);
		end
	end

	assign out_req = out_q;
endmodule
`default_nettype wire

// ----- hdl/heap_spray_byte_scanner.sv -----
`default_nettype none
// Heap spray byte scanner.
// Requests on in_* carry one byte of a memory region each; last marks the final
// byte, and region_size is sampled with it. One request is accepted per cycle
// while scanning. Bytes past the maximum region length are ignored, but a last
// request still closes the region.
// After the last request the block runs five steps of a bit-serial divider that
// forms 30*count/n for the risk score and then assembles the result; only then
// is the result request on out_* valid. in_ready stays low from the last byte
// until the result is taken; a stalled receiver therefore holds the scanner, and
// the result is held unchanged.
// Regions with no last marker produce no result.
// The APB port writes and reads the four configuration registers at 4*i.
// Reset clears all region counters and lanes and loads register defaults.
module heap_spray_byte_scanner (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire hsbs_pkg::in_req_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output hsbs_pkg::out_req_t out_data,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import hsbs_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nop_enable <= 1'b1;
			cfg_q.min_repeat_count <= 21'd100;
			cfg_q.min_density_pct <= 7'd80;
			cfg_q.run_threshold <= 21'd256;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				RegNopEnable: cfg_q.nop_enable <= pwdata[0];
				RegMinRepeat: cfg_q.min_repeat_count <= pwdata[20:0];
				RegMinDensity: cfg_q.min_density_pct <= pwdata[6:0];
				RegRunThresh: cfg_q.run_threshold <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			RegNopEnable: prdata = {31'd0, cfg_q.nop_enable};
			RegMinRepeat: prdata = {11'd0, cfg_q.min_repeat_count};
			RegMinDensity: prdata = {25'd0, cfg_q.min_density_pct};
			RegRunThresh: prdata = {11'd0, cfg_q.run_threshold};
			default: prdata = '0;
		endcase
	end

	hsbs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(in_data.last),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	hsbs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_req(in_data), .cfg(cfg_q), .cmd(cmd),
		.sts(sts), .out_req(out_data)
	);
endmodule
`default_nettype wire

// ----- hdl/hsbs_checker.sv -----
`default_nettype none
module hsbs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire hsbs_pkg::in_req_t in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire hsbs_pkg::out_req_t out_data
);
	import hsbs_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result waits");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last |=> !in_ready) else $error("no judge after last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
	a_risk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.risk_score <= 7'd100) else $error("risk above 100");
endmodule

bind heap_spray_byte_scanner hsbs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
